[src/ascp_pkg.sv]
// ----------------------------------------------------------------------------
// ASCII command line parser package
// Shared constants: character codes, limits, phase codes, register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ascp_pkg;

  // Default number of parameters a command may carry.
  localparam int unsigned MaxParamsDefault = 3;

  // Character codes.
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_ACK  = 8'h06;
  localparam logic [7:0] CH_NAK  = 8'h15;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_CTRL_END = 8'h20;

  // Largest field values that still take one more digit without overflow.
  localparam logic [15:0] DEC_LIMIT = 16'd6553;
  localparam logic [15:0] HEX_LIMIT = 16'h0FFF;
  localparam logic [3:0]  DEC_LAST_DIGIT = 4'd5;

  // Register reset values.
  localparam logic [7:0]  SEP_RESET     = 8'd44;
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;

  // Request types.
  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_VERDICT = 2'd2;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  // Parser phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_PARAMS = 2'd1;
  localparam logic [1:0] PH_WAIT   = 2'd2;

  // Result kinds.
  localparam logic KIND_TX  = 1'b0;
  localparam logic KIND_REC = 1'b1;

  // Configuration register indexes.
  localparam logic REG_SEPARATOR = 1'b0;
  localparam logic REG_TIMEOUT   = 1'b1;

endpackage

`default_nettype wire

[src/ascii_command_line_parser.sv]
// ----------------------------------------------------------------------------
// ASCII command line parser
// Parses a command character and up to MAX_PARAMS decimal or hex parameters
// from received bytes, answers with ACK/NAK and emits parsed command records.
// ----------------------------------------------------------------------------
// Results: the results of an accepted item are registered into the result queue
//   and presented from its head.
// Throughput: one item per cycle unless stalled. A command run of n records
//   leaves the output at one record per cycle unless out_stall_i is set; two pending
//   result groups fill the result queue and stall the input until the head group drains.
// Reset: asynchronous, active low; the parser returns to idle, registers take
//   separator 44 and timeout 200, and the result queue empties.
`timescale 1ns / 1ps
`default_nettype none

module ascii_command_line_parser
  import ascp_pkg::*;
#(
  parameter int unsigned MAX_PARAMS = MaxParamsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        verdict_ok_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             out_kind_o,
  output logic [7:0]       tx_byte_o,
  output logic [7:0]       command_code_o,
  output logic [3:0]       param_count_o,
  output logic [2:0]       param_index_o,
  output logic [15:0]      param_value_o,
  output logic             last_record_o
);

  localparam int unsigned IdxW = $clog2(MAX_PARAMS);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PARAMS);
  localparam logic [CntW-1:0] OneCnt = CntW'(1);

  // Configuration registers.
  logic [7:0]  sep_q;
  logic [15:0] tmo_q;

  // Parser state.
  logic [1:0]      phase_q, phase_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [CntW-1:0] pn_q, pn_d;
  logic            seen_q, seen_d;
  logic            fresh_q, fresh_d;
  logic            hex_q, hex_d;
  logic [15:0]     quiet_q, quiet_d;
  logic [15:0]     store_q [MAX_PARAMS];

  logic            store_we;
  logic [IdxW-1:0] store_wa;
  logic [15:0]     store_wd;

  // Result queue of two groups; a group is one transmit byte or one command run.
  logic            slot_kind_q [2];
  logic [7:0]      slot_tx_q   [2];
  logic [7:0]      slot_cmd_q  [2];
  logic [CntW-1:0] slot_cnt_q  [2];
  logic [15:0]     slot_val_q  [2][MAX_PARAMS];
  logic            wr_q, rd_q;
  logic [1:0]      count_q;
  logic [IdxW-1:0] rec_q;

  logic            push;
  logic            push_kind;
  logic [7:0]      push_tx;
  logic [CntW-1:0] push_cnt;

  logic            in_acc, out_acc, pop;
  logic            head_last;
  logic [CntW-1:0] head_recs;

  // Digit evaluation for the current field.
  logic [15:0]     cur_v;
  logic [CntW-1:0] pn_next;
  logic [15:0]     quiet_inc;
  logic [3:0]      dig;
  logic            hex_dig_ok, dec_dig_ok, digit_ok;
  logic [15:0]     digit_val;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (count_q == 2'd2);
  assign in_acc      = in_valid_i && !in_stall_o;

  assign cur_v     = store_q[pn_q[IdxW-1:0]];
  assign pn_next   = pn_q + CntW'(seen_q);
  assign quiet_inc = (quiet_q == 16'hFFFF) ? quiet_q : quiet_q + 16'd1;

  always_comb begin
    hex_dig_ok = 1'b1;
    dig        = 4'd0;
    if (rx_byte_i >= "0" && rx_byte_i <= "9") begin
      dig = 4'(rx_byte_i - "0");
    end else if (rx_byte_i >= "A" && rx_byte_i <= "F") begin
      dig = 4'(rx_byte_i - "A") + 4'd10;
    end else if (rx_byte_i >= "a" && rx_byte_i <= "f") begin
      dig = 4'(rx_byte_i - "a") + 4'd10;
    end else begin
      hex_dig_ok = 1'b0;
    end
    dec_dig_ok = (rx_byte_i >= "0") && (rx_byte_i <= "9");
    if (hex_q) begin
      digit_ok  = hex_dig_ok && (cur_v <= HEX_LIMIT);
      digit_val = {cur_v[11:0], dig};
    end else begin
      digit_ok  = dec_dig_ok &&
                  ((cur_v < DEC_LIMIT) || (cur_v == DEC_LIMIT && dig <= DEC_LAST_DIGIT));
      digit_val = 16'(cur_v * 16'd10) + {12'd0, dig};
    end
  end

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    pn_d      = pn_q;
    seen_d    = seen_q;
    fresh_d   = fresh_q;
    hex_d     = hex_q;
    quiet_d   = quiet_q;
    store_we  = 1'b0;
    store_wa  = pn_q[IdxW-1:0];
    store_wd  = 16'd0;
    push      = 1'b0;
    push_kind = KIND_TX;
    push_tx   = CH_ACK;
    push_cnt  = '0;

    if (in_acc) begin
      unique case (req_type_i)
        REQ_TICK: begin
          if (phase_q == PH_PARAMS) begin
            quiet_d = quiet_inc;
            if (quiet_inc >= tmo_q) begin
              phase_d = PH_IDLE;
              pn_d    = '0;
              seen_d  = 1'b0;
              fresh_d = 1'b0;
              hex_d   = 1'b0;
              quiet_d = '0;
            end
          end
        end
        REQ_VERDICT: begin
          if (phase_q == PH_WAIT) begin
            phase_d = PH_IDLE;
            pn_d    = '0;
            seen_d  = 1'b0;
            fresh_d = 1'b0;
            hex_d   = 1'b0;
            quiet_d = '0;
            push    = 1'b1;
            push_tx = verdict_ok_i ? CH_ACK : CH_NAK;
          end
        end
        REQ_BYTE: begin
          if (phase_q == PH_IDLE) begin
            if (rx_byte_i == CH_CR) begin
              push = 1'b1;
            end else if (rx_byte_i >= CH_CTRL_END) begin
              cmd_d    = rx_byte_i;
              pn_d     = '0;
              seen_d   = 1'b0;
              fresh_d  = 1'b1;
              hex_d    = 1'b0;
              quiet_d  = '0;
              store_we = 1'b1;
              store_wa = '0;
              phase_d  = PH_PARAMS;
            end
          end else if (phase_q == PH_PARAMS) begin
            quiet_d = '0;
            priority if (rx_byte_i == sep_q) begin
              if (pn_next >= MaxCnt) begin
                // A separator that would open a field past the last slot means too many parameters.
                phase_d = PH_IDLE;
                pn_d    = '0;
                seen_d  = 1'b0;
                fresh_d = 1'b0;
                hex_d   = 1'b0;
                push    = 1'b1;
                push_tx = CH_NAK;
              end else begin
                pn_d     = pn_next;
                hex_d    = 1'b0;
                fresh_d  = 1'b1;
                store_we = 1'b1;
                store_wa = pn_next[IdxW-1:0];
              end
            end else if (rx_byte_i == CH_CR) begin
              pn_d      = pn_next;
              phase_d   = PH_WAIT;
              push      = 1'b1;
              push_kind = KIND_REC;
              push_cnt  = pn_next;
            end else if (rx_byte_i == CH_ESC) begin
              phase_d = PH_IDLE;
              pn_d    = '0;
              seen_d  = 1'b0;
              fresh_d = 1'b0;
              hex_d   = 1'b0;
            end else if (fresh_q && rx_byte_i == CH_HASH) begin
              hex_d = 1'b1;
            end else begin
              seen_d  = 1'b1;
              fresh_d = 1'b0;
              if (digit_ok) begin
                store_we = 1'b1;
                store_wd = digit_val;
              end else begin
                phase_d = PH_IDLE;
                pn_d    = '0;
                seen_d  = 1'b0;
                fresh_d = 1'b0;
                hex_d   = 1'b0;
                push    = 1'b1;
                push_tx = CH_NAK;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output side: the head group is shown record by record.
  assign head_recs = (slot_cnt_q[rd_q] == '0) ? OneCnt : slot_cnt_q[rd_q];
  assign head_last = (slot_kind_q[rd_q] == KIND_TX) ||
                     (({1'b0, rec_q} + OneCnt) == head_recs);
  assign out_valid_o = (count_q != 2'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign pop         = out_acc && head_last;

  always_comb begin
    out_kind_o     = slot_kind_q[rd_q];
    tx_byte_o      = 8'd0;
    command_code_o = 8'd0;
    param_count_o  = 4'd0;
    param_index_o  = 3'd0;
    param_value_o  = 16'd0;
    last_record_o  = 1'b0;
    if (slot_kind_q[rd_q] == KIND_TX) begin
      tx_byte_o = slot_tx_q[rd_q];
    end else begin
      command_code_o = slot_cmd_q[rd_q];
      param_count_o  = 4'(slot_cnt_q[rd_q]);
      param_index_o  = 3'(rec_q);
      param_value_o  = (slot_cnt_q[rd_q] == '0) ? 16'd0 : slot_val_q[rd_q][rec_q];
      last_record_o  = head_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= SEP_RESET;
      tmo_q   <= TIMEOUT_RESET;
      phase_q <= PH_IDLE;
      cmd_q   <= '0;
      pn_q    <= '0;
      seen_q  <= 1'b0;
      fresh_q <= 1'b0;
      hex_q   <= 1'b0;
      quiet_q <= '0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
      rec_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_SEPARATOR: sep_q <= cfg_data_i[7:0];
          REG_TIMEOUT:   tmo_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      pn_q    <= pn_d;
      seen_q  <= seen_d;
      fresh_q <= fresh_d;
      hex_q   <= hex_d;
      quiet_q <= quiet_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
      if (out_acc) begin
        rec_q <= pop ? '0 : rec_q + IdxW'(1);
      end
    end
  end

  // Payload storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[store_wa] <= store_wd;
    end
    if (push) begin
      slot_kind_q[wr_q] <= push_kind;
      slot_tx_q[wr_q]   <= push_tx;
      slot_cmd_q[wr_q]  <= cmd_q;
      slot_cnt_q[wr_q]  <= push_cnt;
      for (int i = 0; i < int'(MAX_PARAMS); i++) begin
        slot_val_q[wr_q][i] <= store_q[i];
      end
    end
  end

  // The result queue never holds more than two groups.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result queue count out of range");

  // A record that is not the last of its run advances the record index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !head_last) |=> (rec_q == $past(rec_q) + IdxW'(1)))
    else $error("record index did not advance");

  // Transmit results carry only ACK or NAK and never mark a run end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == KIND_TX) |->
      ((tx_byte_o == CH_ACK || tx_byte_o == CH_NAK) && !last_record_o))
    else $error("malformed transmit result");

  // Record positions stay below the parameter limit and counts do not exceed it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == KIND_REC) |->
      (32'(param_index_o) < MAX_PARAMS && 32'(param_count_o) <= MAX_PARAMS))
    else $error("record index or count beyond parameter limit");

  // While parsing, the field pointer addresses a valid store entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PARAMS) |-> (pn_q < MaxCnt))
    else $error("parameter pointer out of range");

endmodule

`default_nettype wire

[sim/ascii_command_line_parser_tb.sv]
// ----------------------------------------------------------------------------
// ASCII command line parser testbench
// Feeds bytes, ticks and verdicts through the input channel and checks every
// ACK/NAK byte and command record against a cycle-free model of the parser.
// Covers directed corner cases, then random command traffic under four idling
// patterns and four register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ascii_command_line_parser_tb;
  import ascp_pkg::*;

  localparam int unsigned MAX_FIELDS = MaxParamsDefault;
  localparam int unsigned FIELD_IDX_W = $clog2(MAX_FIELDS);
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic [7:0]  cmd;
    logic [3:0]  count;
    logic [2:0]  index;
    logic [15:0] value;
    logic        last;
  } parser_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = REG_SEPARATOR;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = REQ_BYTE;
  logic [7:0]  rx_byte_i = '0;
  logic        verdict_ok_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        out_kind_o;
  logic [7:0]  tx_byte_o;
  logic [7:0]  command_code_o;
  logic [3:0]  param_count_o;
  logic [2:0]  param_index_o;
  logic [15:0] param_value_o;
  logic        last_record_o;

  // Model of the parser state and registers.
  logic [1:0]  phase_q = PH_IDLE;
  logic [7:0]  cmd_q = '0;
  logic [15:0] field_q [MAX_FIELDS];
  logic [3:0]  field_num_q = '0;
  logic        seen_digit_q = 1'b0;
  logic        fresh_field_q = 1'b0;
  logic        hex_mode_q = 1'b0;
  logic [15:0] quiet_q = '0;
  logic [7:0]  separator_q = SEP_RESET;
  logic [15:0] timeout_q = TIMEOUT_RESET;

  parser_reply_t pending_replies [$];
  int unsigned   error_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   cycle_count = 0;
  int unsigned   gap_pct = 0;
  int unsigned   stall_pct = 0;

  ascii_command_line_parser u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .rx_byte_i      (rx_byte_i),
    .verdict_ok_i   (verdict_ok_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_kind_o     (out_kind_o),
    .tx_byte_o      (tx_byte_o),
    .command_code_o (command_code_o),
    .param_count_o  (param_count_o),
    .param_index_o  (param_index_o),
    .param_value_o  (param_value_o),
    .last_record_o  (last_record_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ascii_command_line_parser regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic push_tx(input logic [7:0] code);
    parser_reply_t r;
    r = '0;
    r.kind = KIND_TX;
    r.tx = code;
    pending_replies.push_back(r);
  endtask

  task automatic drop_command();
    phase_q = PH_IDLE;
    field_num_q = '0;
    seen_digit_q = 1'b0;
    fresh_field_q = 1'b0;
    hex_mode_q = 1'b0;
    quiet_q = '0;
  endtask

  // Advances the model by one accepted transaction and queues its replies.
  task automatic parse_event(input logic [1:0] req, input logic [7:0] c, input logic ok);
    parser_reply_t r;
    int unsigned   n;
    int unsigned   recs;
    int unsigned   v;
    int unsigned   d;
    bit            good;
    case (req)
      REQ_TICK: begin
        if (phase_q == PH_PARAMS) begin
          if (quiet_q != 16'hFFFF) quiet_q++;
          if (quiet_q >= timeout_q) drop_command();
        end
      end
      REQ_VERDICT: begin
        if (phase_q == PH_WAIT) begin
          drop_command();
          push_tx(ok ? CH_ACK : CH_NAK);
        end
      end
      REQ_BYTE: begin
        if (phase_q == PH_IDLE) begin
          if (c == CH_CR) begin
            push_tx(CH_ACK);
          end else if (c >= CH_CTRL_END) begin
            cmd_q = c;
            field_num_q = '0;
            seen_digit_q = 1'b0;
            fresh_field_q = 1'b1;
            hex_mode_q = 1'b0;
            quiet_q = '0;
            field_q[0] = '0;
            phase_q = PH_PARAMS;
          end
        end else if (phase_q == PH_PARAMS) begin
          quiet_q = '0;
          if (c == separator_q) begin
            if (seen_digit_q) field_num_q++;
            hex_mode_q = 1'b0;
            fresh_field_q = 1'b1;
            if (field_num_q >= MAX_FIELDS) begin
              drop_command();
              push_tx(CH_NAK);
            end else begin
              field_q[field_num_q[FIELD_IDX_W-1:0]] = '0;
            end
          end else if (c == CH_CR) begin
            if (seen_digit_q) field_num_q++;
            phase_q = PH_WAIT;
            n = 32'(field_num_q);
            recs = (n == 0) ? 1 : n;
            for (int unsigned i = 0; i < recs; i++) begin
              r = '0;
              r.kind = KIND_REC;
              r.cmd = cmd_q;
              r.count = n[3:0];
              r.index = i[2:0];
              r.value = (n == 0) ? 16'd0 : field_q[i];
              r.last = (i + 1 == recs);
              pending_replies.push_back(r);
            end
          end else if (c == CH_ESC) begin
            drop_command();
          end else if (fresh_field_q && c == CH_HASH) begin
            hex_mode_q = 1'b1;
          end else begin
            seen_digit_q = 1'b1;
            fresh_field_q = 1'b0;
            v = 32'(field_q[field_num_q[FIELD_IDX_W-1:0]]);
            d = 0;
            good = 1'b1;
            if (hex_mode_q) begin
              if (c >= "0" && c <= "9") d = 32'(c - "0");
              else if (c >= "A" && c <= "F") d = 32'(c - "A") + 10;
              else if (c >= "a" && c <= "f") d = 32'(c - "a") + 10;
              else good = 1'b0;
              if (v > HEX_LIMIT) good = 1'b0;
              v = v * 16 + d;
            end else begin
              if (c < "0" || c > "9") good = 1'b0;
              else d = 32'(c - "0");
              if (v > DEC_LIMIT || (v == DEC_LIMIT && d > DEC_LAST_DIGIT)) good = 1'b0;
              v = v * 10 + d;
            end
            if (good) begin
              field_q[field_num_q[FIELD_IDX_W-1:0]] = v[15:0];
            end else begin
              drop_command();
              push_tx(CH_NAK);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    parser_reply_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected reply kind %0d tx %02h", out_kind_o, tx_byte_o));
      end else begin
        e = pending_replies.pop_front();
        if (out_kind_o !== e.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_kind_o, e.kind));
        if (tx_byte_o !== e.tx)
          report_mismatch($sformatf("tx_byte %02h, want %02h", tx_byte_o, e.tx));
        if (command_code_o !== e.cmd)
          report_mismatch($sformatf("command %02h, want %02h", command_code_o, e.cmd));
        if (param_count_o !== e.count)
          report_mismatch($sformatf("count %0d, want %0d", param_count_o, e.count));
        if (param_index_o !== e.index)
          report_mismatch($sformatf("index %0d, want %0d", param_index_o, e.index));
        if (param_value_o !== e.value)
          report_mismatch($sformatf("value %0d, want %0d", param_value_o, e.value));
        if (last_record_o !== e.last)
          report_mismatch($sformatf("last %0d, want %0d", last_record_o, e.last));
      end
    end
  end

  // Valid stays high between back-to-back transactions; it drops for a gap and in drain().
  task automatic send_item(input logic [1:0] req, input logic [7:0] b, input logic ok);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < gap_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    rx_byte_i <= b;
    verdict_ok_i <= ok;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_event(req, b, ok);
    items_sent++;
  endtask

  task automatic send_text(input string s, input bit chatter);
    for (int i = 0; i < s.len(); i++) begin
      send_item(REQ_BYTE, s[i], 1'($urandom_range(0, 1)));
      if (chatter && $urandom_range(0, 15) == 0)
        send_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Leaves the parser idle and quiet, then writes both registers.
  task automatic reconfigure(input logic [7:0] sep, input logic [15:0] ticks);
    if (phase_q == PH_PARAMS) send_item(REQ_BYTE, CH_ESC, 1'b0);
    else if (phase_q == PH_WAIT) send_item(REQ_VERDICT, 8'h00, 1'b1);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_SEPARATOR;
    cfg_data_i <= {8'h00, sep};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    separator_q = sep;
    cfg_index_i <= REG_TIMEOUT;
    cfg_data_i <= ticks;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    timeout_q = ticks;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_idle_events();
    send_item(REQ_BYTE, CH_CR, 1'b0);
    send_item(REQ_BYTE, 8'h1F, 1'b1);
    send_item(REQ_TICK, 8'hFF, 1'b1);
    send_item(REQ_VERDICT, 8'h00, 1'b1);
    send_item(REQ_UNUSED, 8'hFF, 1'b1);
  endtask

  task automatic test_decimal_fields();
    send_text("A65535\r", 1'b0);
    send_item(REQ_BYTE, 8'h41, 1'b1);
    send_item(REQ_VERDICT, 8'h00, 1'b0);
    send_text("B65536", 1'b0);
    send_text("Q\r", 1'b0);
    send_item(REQ_VERDICT, 8'hFF, 1'b1);
  endtask

  task automatic test_hex_and_empty_fields();
    send_text("h#FfFf,,#0\r", 1'b0);
    send_item(REQ_VERDICT, 8'h00, 1'b1);
    send_text("x,1#", 1'b0);
  endtask

  task automatic test_timeout_and_separator();
    reconfigure(8'h00, 16'd1);
    send_text("T1", 1'b0);
    send_item(REQ_BYTE, 8'h00, 1'b0);
    send_text("2", 1'b0);
    send_item(REQ_TICK, 8'h00, 1'b0);
    send_item(REQ_BYTE, CH_CR, 1'b0);
  endtask

  task automatic send_command();
    string       s;
    int unsigned fields;
    int unsigned v;
    int unsigned pick;
    byte         ch;
    send_item(REQ_BYTE, 8'($urandom_range(32, 255)), 1'($urandom_range(0, 1)));
    fields = $urandom_range(0, 4);
    for (int unsigned f = 0; f < fields; f++) begin
      if (f != 0) send_item(REQ_BYTE, separator_q, 1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 9);
      v = $urandom_range(0, 1) ? $urandom_range(0, 99) : $urandom_range(0, 65535);
      if (pick == 0) begin
        s = "";
      end else if (pick <= 4) begin
        s = $sformatf("%0d", v);
      end else if (pick <= 7) begin
        s = $sformatf("%0h", v);
        for (int i = 0; i < s.len(); i++) begin
          ch = s[i];
          if (ch >= "a" && $urandom_range(0, 1)) s[i] = ch - 8'h20;
        end
        s = {"#", s};
      end else if (pick == 8) begin
        // Near or past the 16-bit limit.
        s = $sformatf("%0d%0d", $urandom_range(6553, 6554), $urandom_range(0, 9));
      end else begin
        s = string'(byte'($urandom_range(0, 255)));
      end
      send_text(s, 1'b1);
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      send_item(REQ_BYTE, CH_ESC, 1'($urandom_range(0, 1)));
    end else begin
      if (pick == 1)
        repeat (timeout_q <= 8 ? timeout_q : 3)
          send_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_item(REQ_BYTE, CH_CR, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0)
        send_item(REQ_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_item(REQ_VERDICT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_traffic(input int unsigned gaps, input int unsigned stalls,
                                     input logic [7:0] sep, input logic [15:0] ticks,
                                     input bit hold_off);
    int unsigned target;
    int unsigned midway;
    bit          paused;
    reconfigure(sep, ticks);
    gap_pct = gaps;
    stall_pct = stalls;
    target = items_sent + 12;
    midway = items_sent + 6;
    paused = 1'b0;
    while (items_sent < target) begin
      if ($urandom_range(0, 4) == 0)
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      else
        send_command();
      // Once past midway, if hold_off is set, the sender holds off until every queued reply has come out.
      if (hold_off && !paused && items_sent >= midway) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_events();
    test_decimal_fields();
    test_hex_and_empty_fields();
    test_timeout_and_separator();
    test_random_traffic(0, 0, SEP_RESET, TIMEOUT_RESET, 1'b1);
    test_random_traffic(56, 0, 8'hFF, 16'd2, 1'b0);
    test_random_traffic(0, 56, 8'h00, 16'hFFFF, 1'b0);
    test_random_traffic(16, 16, 8'h20, 16'd5, 1'b0);
    drain();
    if (error_count == 0) begin
      $display("ascii_command_line_parser regression: pass");
    end else begin
      $display("ascii_command_line_parser regression: fail");
    end
    $finish;
  end

endmodule
